FILE: sv/cmm_pkg.sv
// Shared types and constants for the confusion-matrix measures block.
// No dependencies; imported by every module of the block.
package cmm_pkg;

	localparam int CNT_BITS_DEF  = 24;
	localparam int FRAC_BITS_DEF = 16;
	localparam int ADDR_BITS     = 4;

	localparam logic [1:0] REG_POS   = 2'd0;
	localparam logic [1:0] REG_NEG   = 2'd1;
	localparam logic [1:0] REG_RANKS = 2'd2;

	typedef enum logic [3:0] {
		OP_RANK, OP_ERR, OP_SPEC, OP_SENS, OP_PREC, OP_FSC,
		OP_MA, OP_MB, OP_M01, OP_M23, OP_NSQ, OP_DEN, OP_MDIV, OP_SQRT
	} op_t;

	typedef enum logic [1:0] {EM_NONE, EM_SHORT, EM_HELD, EM_CUR} em_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CALC, ST_WAIT, ST_STORE, ST_HELD, ST_CUR, ST_SHORT
	} st_t;

	typedef struct packed {
		logic start;
		op_t  op;
		logic load_in;
		logic store_held;
		em_t  emit;
		logic rank_step;
		logic rank_clear;
	} cmd_t;

	typedef struct packed {
		logic short_set;
		logic first;
		logic second;
		logic done;
		logic out_free;
	} stat_t;

endpackage

FILE: sv/cmm_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, early exit on zero.
// Depends on cmm_pkg.
module cmm_mul import cmm_pkg::*; #(
	parameter int MW = 2 * CNT_BITS_DEF + 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [MW-1:0]   a,
	input  logic [MW-1:0]   b,
	output logic            done,
	output logic [2*MW-1:0] prod
);
	logic            busy_q, done_q;
	logic [2*MW-1:0] acc_q, mc_q;
	logic [MW-1:0]   mp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && mp_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mc_q  <= (2*MW)'(a);
			mp_q  <= b;
		end else if (busy_q && mp_q != '0) begin
			if (mp_q[0]) acc_q <= acc_q + mc_q;
			mc_q <= {mc_q[2*MW-2:0], 1'b0};
			mp_q <= mp_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule

FILE: sv/cmm_div.sv
// Restoring fraction divider: floor(num*2^steps/den), saturating when num >= den.
// Depends on cmm_pkg.
module cmm_div import cmm_pkg::*; #(
	parameter int DW = 4 * CNT_BITS_DEF + 4,
	parameter int QW = 2 * FRAC_BITS_DEF,
	parameter int SW = $clog2(QW + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] steps,
	output logic          done,
	output logic          sat,
	output logic [QW-1:0] quo
);
	logic          busy_q, done_q, sat_q;
	logic [DW-1:0] r_q, d_q;
	logic [QW-1:0] q_q;
	logic [SW-1:0] cnt_q;
	logic [DW:0]   r2;

	assign r2 = {r_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !(num >= den);
				done_q <= num >= den;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sat_q <= num >= den;
			r_q   <= num;
			d_q   <= den;
			q_q   <= '0;
			cnt_q <= steps;
		end else if (busy_q && cnt_q != '0) begin
			if (r2 >= {1'b0, d_q}) begin
				r_q <= DW'(r2 - {1'b0, d_q});
				q_q <= {q_q[QW-2:0], 1'b1};
			end else begin
				r_q <= DW'(r2);
				q_q <= {q_q[QW-2:0], 1'b0};
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign done = done_q;
	assign sat  = sat_q;
	assign quo  = q_q;
endmodule

FILE: sv/cmm_sqrt.sv
// Integer square root, one result bit per cycle by trial squaring.
// Depends on cmm_pkg.
module cmm_sqrt import cmm_pkg::*; #(
	parameter int F = FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [2*F-1:0] y,
	output logic           done,
	output logic [F-1:0]   root
);
	logic           busy_q, done_q;
	logic [F-1:0]   res_q, bit_q, c;
	logic [2*F-1:0] y_q, sq;

	assign c  = res_q | bit_q;
	assign sq = (2*F)'(c) * (2*F)'(c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			res_q <= '0;
			bit_q <= {1'b1, {(F-1){1'b0}}};
			y_q   <= y;
		end else if (busy_q) begin
			if (sq <= y_q) res_q <= c;
			bit_q <= bit_q >> 1;
		end
	end

	assign done = done_q;
	assign root = res_q;
endmodule

FILE: sv/cmm_dp.sv
// Datapath: input capture, shared multiplier/divider/root units, result and
// held-row registers, rank counter and output register. Depends on cmm_pkg.
module cmm_dp import cmm_pkg::*; #(
	parameter int C = CNT_BITS_DEF,
	parameter int F = FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cmd_t          cmd,
	output stat_t         st,
	input  logic [C-1:0]  cfg_pos,
	input  logic [C-1:0]  cfg_neg,
	input  logic [C-1:0]  cfg_ranks,
	input  logic [4*C-1:0] in_data,
	input  logic          out_ready,
	output logic          out_valid,
	output logic [F:0]    o_rank, o_err, o_acc, o_spec, o_sens, o_prec, o_fsc,
	output logic [F+1:0]  o_mcc,
	output logic [5:0]    o_mask,
	output logic          o_size,
	output logic          o_last
);
	localparam int MW = 2 * C + 2;
	localparam int DW = 2 * MW;
	localparam int QW = 2 * F;
	localparam int SW = $clog2(QW + 1);

	logic [C-1:0]  tp_q, fp_q, tn_q, fn_q, ri_q;
	logic [C:0]    tpfp, tpfn, tnfp, tnfn, fpfn, pn, tp2;
	logic [C+1:0]  fd;
	logic [2*C-1:0] ma_q, mb_q, nabs;
	logic [MW-1:0] p01_q, p23_q, mul_a, mul_b;
	logic [DW-1:0] nsq_q, den_q, div_num, div_den, prod;
	logic [SW-1:0] div_steps;
	logic [QW-1:0] y_q, quo;
	logic          msat_q, mul_done, div_done, div_sat, sqrt_done;
	logic [F-1:0]  root;
	logic [F:0]    one, frac, rank_q, err_q, spec_q, sens_q, prec_q, fsc_q;
	logic [F:0]    mag;
	logic [F+1:0]  mcc_q;
	logic          is_mul, is_div, is_sqrt;
	logic [5:0]    mask, held_mask_q;
	logic [F:0]    g_err, g_acc, g_spec, g_sens, g_prec, g_fsc;
	logic [F+1:0]  g_mcc;
	logic [F:0]    h_err_q, h_acc_q, h_spec_q, h_sens_q, h_fsc_q;
	logic [F+1:0]  h_mcc_q;
	logic          vld_q, is_last;

	assign tpfp = {1'b0, tp_q} + {1'b0, fp_q};
	assign tpfn = {1'b0, tp_q} + {1'b0, fn_q};
	assign tnfp = {1'b0, tn_q} + {1'b0, fp_q};
	assign tnfn = {1'b0, tn_q} + {1'b0, fn_q};
	assign fpfn = {1'b0, fp_q} + {1'b0, fn_q};
	assign pn   = {1'b0, cfg_pos} + {1'b0, cfg_neg};
	assign tp2  = {tp_q, 1'b0};
	assign fd   = {1'b0, tp2} + {1'b0, fpfn};
	assign nabs = (ma_q >= mb_q) ? ma_q - mb_q : mb_q - ma_q;
	assign one  = {1'b1, {F{1'b0}}};

	always_comb begin
		is_mul = 1'b0;
		is_div = 1'b0;
		is_sqrt = 1'b0;
		mul_a = '0;
		mul_b = '0;
		div_num = '0;
		div_den = '0;
		div_steps = SW'(F);
		case (cmd.op)
			OP_RANK: begin
				is_div = 1'b1;
				div_num = DW'(ri_q);
				div_den = DW'(cfg_ranks - 1'b1);
			end
			OP_ERR: begin
				is_div = 1'b1;
				div_num = DW'(fpfn);
				div_den = DW'(pn);
			end
			OP_SPEC: begin
				is_div = 1'b1;
				div_num = DW'(tn_q);
				div_den = DW'(cfg_neg);
			end
			OP_SENS: begin
				is_div = 1'b1;
				div_num = DW'(tp_q);
				div_den = DW'(cfg_pos);
			end
			OP_PREC: begin
				is_div = 1'b1;
				div_num = DW'(tp_q);
				div_den = DW'(tpfp);
			end
			OP_FSC: begin
				is_div = 1'b1;
				div_num = DW'(tp2);
				div_den = DW'(fd);
			end
			OP_MA: begin
				is_mul = 1'b1;
				mul_a = MW'(tp_q);
				mul_b = MW'(tn_q);
			end
			OP_MB: begin
				is_mul = 1'b1;
				mul_a = MW'(fp_q);
				mul_b = MW'(fn_q);
			end
			OP_M01: begin
				is_mul = 1'b1;
				mul_a = MW'(tpfp);
				mul_b = MW'(tpfn);
			end
			OP_M23: begin
				is_mul = 1'b1;
				mul_a = MW'(tnfp);
				mul_b = MW'(tnfn);
			end
			OP_NSQ: begin
				is_mul = 1'b1;
				mul_a = MW'(nabs);
				mul_b = MW'(nabs);
			end
			OP_DEN: begin
				is_mul = 1'b1;
				mul_a = p01_q;
				mul_b = p23_q;
			end
			OP_MDIV: begin
				is_div = 1'b1;
				div_num = nsq_q;
				div_den = den_q;
				div_steps = SW'(QW);
			end
			OP_SQRT: is_sqrt = 1'b1;
			default: ;
		endcase
	end

	cmm_mul #(.MW(MW)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(cmd.start && is_mul),
		.a(mul_a), .b(mul_b), .done(mul_done), .prod(prod)
	);

	cmm_div #(.DW(DW), .QW(QW), .SW(SW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.start && is_div),
		.num(div_num), .den(div_den), .steps(div_steps),
		.done(div_done), .sat(div_sat), .quo(quo)
	);

	cmm_sqrt #(.F(F)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(cmd.start && is_sqrt),
		.y(y_q), .done(sqrt_done), .root(root)
	);

	assign frac = div_sat ? one : {1'b0, quo[F-1:0]};
	assign mag  = msat_q ? one : {1'b0, root};

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			tp_q <= in_data[C-1:0];
			fp_q <= in_data[2*C-1:C];
			tn_q <= in_data[3*C-1:2*C];
			fn_q <= in_data[4*C-1:3*C];
		end
		if (div_done) begin
			case (cmd.op)
				OP_RANK: rank_q <= frac;
				OP_ERR:  err_q  <= frac;
				OP_SPEC: spec_q <= frac;
				OP_SENS: sens_q <= frac;
				OP_PREC: prec_q <= frac;
				OP_FSC:  fsc_q  <= frac;
				OP_MDIV: begin
					msat_q <= div_sat;
					y_q    <= quo;
				end
				default: ;
			endcase
		end
		if (mul_done) begin
			case (cmd.op)
				OP_MA:  ma_q  <= prod[2*C-1:0];
				OP_MB:  mb_q  <= prod[2*C-1:0];
				OP_M01: p01_q <= prod[MW-1:0];
				OP_M23: p23_q <= prod[MW-1:0];
				OP_NSQ: nsq_q <= prod;
				OP_DEN: den_q <= prod;
				default: ;
			endcase
		end
		if (sqrt_done) mcc_q <= (mb_q > ma_q) ? (F+2)'(-{1'b0, mag}) : {1'b0, mag};
	end

	assign mask[0] = pn == '0;
	assign mask[1] = cfg_neg == '0;
	assign mask[2] = cfg_pos == '0;
	assign mask[3] = tpfp == '0;
	assign mask[4] = tpfp == '0 || tpfn == '0 || tnfp == '0 || tnfn == '0;
	assign mask[5] = fd == '0;

	assign g_err  = mask[0] ? '0 : err_q;
	assign g_acc  = mask[0] ? '0 : one - err_q;
	assign g_spec = mask[1] ? '0 : spec_q;
	assign g_sens = mask[2] ? '0 : sens_q;
	assign g_prec = mask[3] ? '0 : prec_q;
	assign g_mcc  = mask[4] ? '0 : mcc_q;
	assign g_fsc  = mask[5] ? '0 : fsc_q;

	assign is_last = ({1'b0, ri_q} + 1'b1) >= {1'b0, cfg_ranks};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ri_q        <= '0;
			held_mask_q <= '0;
		end else begin
			if (cmd.rank_clear) ri_q <= '0;
			else if (cmd.rank_step) ri_q <= is_last ? '0 : C'(ri_q + 1'b1);
			if (cmd.store_held) held_mask_q <= mask & 6'b110111;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store_held) begin
			h_err_q  <= g_err;
			h_acc_q  <= g_acc;
			h_spec_q <= g_spec;
			h_sens_q <= g_sens;
			h_mcc_q  <= g_mcc;
			h_fsc_q  <= g_fsc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (cmd.emit != EM_NONE) vld_q <= 1'b1;
		else if (out_ready) vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		unique case (cmd.emit)
			EM_SHORT: begin
				o_rank <= '0; o_err <= '0; o_acc <= '0; o_spec <= '0;
				o_sens <= '0; o_prec <= '0; o_mcc <= '0; o_fsc <= '0;
				o_mask <= '0; o_size <= 1'b1; o_last <= 1'b1;
			end
			EM_HELD: begin
				o_rank <= '0; o_err <= h_err_q; o_acc <= h_acc_q;
				o_spec <= h_spec_q; o_sens <= h_sens_q; o_prec <= g_prec;
				o_mcc <= h_mcc_q; o_fsc <= h_fsc_q;
				o_mask <= held_mask_q | (mask & 6'b001000);
				o_size <= 1'b0; o_last <= 1'b0;
			end
			EM_CUR: begin
				o_rank <= rank_q; o_err <= g_err; o_acc <= g_acc;
				o_spec <= g_spec; o_sens <= g_sens; o_prec <= g_prec;
				o_mcc <= g_mcc; o_fsc <= g_fsc; o_mask <= mask;
				o_size <= 1'b0; o_last <= is_last;
			end
			EM_NONE: ;
		endcase
	end

	assign out_valid   = vld_q;
	assign st.short_set = cfg_ranks < C'(2);
	assign st.first    = ri_q == '0;
	assign st.second   = ri_q == C'(1);
	assign st.out_free = !vld_q || out_ready;
	assign st.done     = (is_mul && mul_done) || (is_div && div_done) ||
	                     (is_sqrt && sqrt_done);
endmodule

FILE: sv/cmm_ctrl.sv
// Controller: sequences the operations of one rank and the result beats.
// Depends on cmm_pkg.
module cmm_ctrl import cmm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t st,
	output cmd_t  cmd
);
	st_t state_q, state_d;
	op_t op_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = st.short_set ? ST_SHORT : ST_CALC;
			ST_CALC:  state_d = ST_WAIT;
			ST_WAIT: begin
				if (st.done) begin
					if (op_q != OP_SQRT) state_d = ST_CALC;
					else if (st.first) state_d = ST_STORE;
					else if (st.second) state_d = ST_HELD;
					else state_d = ST_CUR;
				end
			end
			ST_STORE: state_d = ST_IDLE;
			ST_HELD:  if (st.out_free) state_d = ST_CUR;
			ST_CUR:   if (st.out_free) state_d = ST_IDLE;
			ST_SHORT: if (st.out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.op = op_q;
		cmd.emit = EM_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_CALC: cmd.start = 1'b1;
			ST_STORE: begin
				cmd.store_held = 1'b1;
				cmd.rank_step = 1'b1;
			end
			ST_HELD: if (st.out_free) cmd.emit = EM_HELD;
			ST_CUR: begin
				if (st.out_free) begin
					cmd.emit = EM_CUR;
					cmd.rank_step = 1'b1;
				end
			end
			ST_SHORT: begin
				if (st.out_free) begin
					cmd.emit = EM_SHORT;
					cmd.rank_clear = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_RANK;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) op_q <= OP_RANK;
			else if (state_q == ST_WAIT && st.done && op_q != OP_SQRT)
				op_q <= op_t'(op_q + 4'd1);
		end
	end
endmodule

FILE: sv/confusion_matrix_measures.sv
// Confusion-matrix measures top level: APB registers, controller, datapath.
// Depends on cmm_pkg, cmm_ctrl, cmm_dp (and its mul/div/sqrt units).
// A rank: accept, six divides, six products (multiplier operands at most
// 24/24/25/25/48/50 bits at C=24), MCC divide, root; then rank zero is held, or each
// beat is sent when free; one rank at a time. Ranks < 2: each rank gives a size-error
// beat; else the first rank gives no beat, the second two. Reset: P=1, N=1, ranks=2.
module confusion_matrix_measures import cmm_pkg::*; #(
	parameter int COUNT_BITS = CNT_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	localparam int IW = ((4 * COUNT_BITS + 7) / 8) * 8,
	localparam int OW = ((8 * FRAC_BITS + 15 + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// true_pos, false_pos, true_neg, false_neg
	input  logic [IW-1:0]        s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// norm_rank, error_rate, accuracy, specificity, sensitivity, precision,
	// matthews, f_score, undefined_mask
	output logic [OW-1:0]        m_tdata,
	// size_error
	output logic                 m_tuser,
	output logic                 m_tlast
);
	localparam int C = COUNT_BITS;
	localparam int F = FRAC_BITS;

	logic [C-1:0]   pos_q, neg_q, ranks_q;
	logic           wr;
	cmd_t           cmd;
	stat_t          st;
	logic [F:0]     o_rank, o_err, o_acc, o_spec, o_sens, o_prec, o_fsc;
	logic [F+1:0]   o_mcc;
	logic [5:0]     o_mask;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= C'(1);
			neg_q   <= C'(1);
			ranks_q <= C'(2);
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_POS:   pos_q   <= pwdata[C-1:0];
				REG_NEG:   neg_q   <= pwdata[C-1:0];
				REG_RANKS: ranks_q <= pwdata[C-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_POS:   prdata = 32'(pos_q);
			REG_NEG:   prdata = 32'(neg_q);
			REG_RANKS: prdata = 32'(ranks_q);
			default:   prdata = '0;
		endcase
	end

	cmm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.st(st), .cmd(cmd)
	);

	cmm_dp #(.C(C), .F(F)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.cfg_pos(pos_q), .cfg_neg(neg_q), .cfg_ranks(ranks_q),
		.in_data(s_tdata[4*C-1:0]), .out_ready(m_tready), .out_valid(m_tvalid),
		.o_rank(o_rank), .o_err(o_err), .o_acc(o_acc), .o_spec(o_spec),
		.o_sens(o_sens), .o_prec(o_prec), .o_fsc(o_fsc), .o_mcc(o_mcc),
		.o_mask(o_mask), .o_size(m_tuser), .o_last(m_tlast)
	);

	assign m_tdata = OW'({o_mask, o_fsc, o_mcc, o_prec, o_sens, o_spec, o_acc,
	                      o_err, o_rank});
endmodule
